@@ sv/mtwg_pkg.sv @@
// Shared constants, types and word functions of the Mersenne Twister generator.
`default_nettype none
package mtwg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int WORD_W       = 32;
    localparam int COUNT_W      = $clog2(STATE_WORDS);

    localparam logic [WORD_W-1:0] TW_MATRIX    = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TW_HIGH      = 32'h8000_0000;
    localparam logic [WORD_W-1:0] TW_LOW       = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd69069;
    localparam logic [WORD_W-1:0] SEED_DEFAULT = 32'd4357;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic  active;
        t_word word;
    } t_seed_out;

    function automatic t_word mix_word(input t_word x_lo, input t_word x_nxt,
                                       input t_word x_far);
        t_word y;
        t_word v;
        y = (x_lo & TW_HIGH) | (x_nxt & TW_LOW);
        v = x_far ^ (y >> 1);
        if (y[0]) begin
            v = v ^ TW_MATRIX;
        end
        return v;
    endfunction

    function automatic t_word temper_word(input t_word x);
        t_word y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage
`default_nettype wire

@@ sv/mtwg_cell.sv @@
// One word cell of the state shift line.
`default_nettype none
module mtwg_cell
    import mtwg_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_shift,
    input  t_word i_word,
    output t_word o_word
);

    t_word r_word;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_word;
        end
    end

    assign o_word = r_word;

endmodule
`default_nettype wire

@@ sv/mtwg_seeder.sv @@
// Seed sequencer: feeds the multiplicative seed recurrence into the shift line.
`default_nettype none
module mtwg_seeder
    import mtwg_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_start,
    input  t_word     i_seed,
    output t_seed_out o_seed
);

    logic               r_active;
    logic [COUNT_W-1:0] r_count;
    t_word              r_word;
    t_word              n_word;

    assign n_word = WORD_W'(r_word * SEED_MULT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_count  <= '0;
            r_word   <= SEED_DEFAULT;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_count  <= '0;
            r_word   <= i_seed;
        end else if (r_active) begin
            r_word  <= n_word;
            r_count <= r_count + 1'b1;
            if (r_count == COUNT_W'(STATE_WORDS - 1)) begin
                r_active <= 1'b0;
            end
        end
    end

    assign o_seed.active = r_active;
    assign o_seed.word   = r_word;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_count <= COUNT_W'(STATE_WORDS - 1)))
        else $error("seed count past table end");
    a_idle_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !i_start && r_count == COUNT_W'(STATE_WORDS - 1)) |=> !r_active)
        else $error("seed pass did not end");
    a_start_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_active && r_count == '0))
        else $error("seed pass did not restart");
`endif

endmodule
`default_nettype wire

@@ sv/mersenne_twister_word_generator_core.sv @@
// Top level of the MT19937 word generator built as a shift line of word cells.
// The 624-word state lives in a row of cells that shift by one word per draw: the
// word leaving the head mixes with its neighbor and the word TWIST_OFFSET further
// on, the result enters at the tail and its tempered form is the output beat. One
// word is delivered per clock cycle while draw requests arrive, no seeding pass runs
// and the output is not stalled. After reset and after every seed write a seeding
// pass shifts 624 words of the seed recurrence into the line; s_axis_tready stays
// low during it, while seed writes are still taken at once (a write restarts the
// pass). A request beat with bit 0 clear is accepted and yields no output.
`default_nettype none
module mersenne_twister_word_generator_core
    import mtwg_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [31:0] i_cfg_data,     // seed_value
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [0] draw_request, [7:1] zero
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] random_word
);

    t_seed_out seed;
    t_word     chain [STATE_WORDS];
    t_word     new_word;
    logic      draw;
    logic      shift;
    logic      r_out_valid;
    t_word     r_out_word;

    assign o_cfg_ready = 1'b1;

    mtwg_seeder u_seeder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_valid),
        .i_seed  (i_cfg_data),
        .o_seed  (seed)
    );

    assign new_word = mix_word(chain[0], chain[1], chain[TWIST_OFFSET]);

    assign s_axis_tready = !seed.active && (!r_out_valid || m_axis_tready);
    assign draw          = s_axis_tvalid && s_axis_tready && s_axis_tdata[0];
    assign shift         = seed.active || draw;

    for (genvar g = 0; g < STATE_WORDS; g++) begin : g_cell
        t_word cell_in;
        if (g == STATE_WORDS - 1) begin : g_tail
            assign cell_in = seed.active ? seed.word : new_word;
        end else begin : g_body
            assign cell_in = chain[g+1];
        end
        mtwg_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (shift),
            .i_word  (cell_in),
            .o_word  (chain[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (draw) begin
                r_out_valid <= 1'b1;
            end
        end
        if (draw) begin
            r_out_word <= temper_word(new_word);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;

`ifndef NO_ASSERTIONS
    a_no_draw_seeding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seed.active |-> !s_axis_tready)
        else $error("request taken during seeding");
    a_cfg_reseeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> seed.active)
        else $error("seed write did not start seeding");
    a_draw_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        draw |=> m_axis_tvalid)
        else $error("draw produced no output beat");
`endif

endmodule
`default_nettype wire

@@ bench/tb_mersenne_twister_word_generator_core.sv @@
// Self-checking bench for the MT19937 word generator: seeds, draws and stream stalls.
module tb_mersenne_twister_word_generator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mtwg_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_GAP       = 13;
    localparam int MAX_REPORTS   = 10;
    localparam int UNSEEDED      = STATE_WORDS + 1;

    localparam logic [7:0] REQ_DRAW = 8'h01;
    localparam logic [7:0] REQ_NONE = 8'h00;

    typedef enum logic [1:0] {
        ROW_DRAW,
        ROW_NO_DRAW,
        ROW_SEED
    } t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_word     seed;
        logic      known;
        t_word     word;
    } t_row;

    localparam int NUM_ROWS = 23;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{ROW_DRAW,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_DRAW,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_NO_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_DRAW,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_SEED,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_DRAW,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ROW_DRAW,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ROW_NO_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_DRAW,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ROW_SEED,    32'hffff_ffff, 1'b0, 32'h0000_0000},
        '{ROW_DRAW,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_DRAW,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_SEED,    32'h0000_0001, 1'b0, 32'h0000_0000},
        '{ROW_DRAW,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_DRAW,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_SEED,    SEED_DEFAULT,  1'b0, 32'h0000_0000},
        '{ROW_DRAW,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_NO_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_SEED,    32'h8000_0000, 1'b0, 32'h0000_0000},
        '{ROW_DRAW,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_SEED,    32'h7fff_ffff, 1'b0, 32'h0000_0000},
        '{ROW_DRAW,    32'h0000_0000, 1'b0, 32'h0000_0000},
        '{ROW_DRAW,    32'h0000_0000, 1'b0, 32'h0000_0000}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [0] draw_request, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] random_word

    t_word       word_store [STATE_WORDS];
    int unsigned draw_pos;
    t_word       seed_reg;
    t_word       expected_words [$];

    logic        fixed_valid = 1'b0;
    t_word       fixed_word  = '0;
    logic        src_burst   = 1'b0;
    logic        sink_burst  = 1'b0;
    int unsigned hold_len    = 0;
    int unsigned mismatches  = 0;
    int unsigned cycles      = 0;

    mersenne_twister_word_generator_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_word temper_out(input t_word x);
        t_word y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic void refill_from_seed();
        word_store[0] = seed_reg;
        for (int i = 1; i < STATE_WORDS; i++) begin
            word_store[i] = word_store[i-1] * SEED_MULT;
        end
    endfunction

    function automatic void twist_store();
        int    nxt;
        int    far;
        t_word y;
        t_word v;
        for (int k = 0; k < STATE_WORDS; k++) begin
            nxt = (k + 1) % STATE_WORDS;
            far = (k + TWIST_OFFSET) % STATE_WORDS;
            y = (word_store[k] & TW_HIGH) | (word_store[nxt] & TW_LOW);
            v = word_store[far] ^ (y >> 1);
            if (y[0]) begin
                v = v ^ TW_MATRIX;
            end
            word_store[k] = v;
        end
    endfunction

    function automatic t_word next_word();
        t_word w;
        if (draw_pos >= STATE_WORDS) begin
            if (draw_pos > STATE_WORDS) begin
                refill_from_seed();
            end
            twist_store();
            draw_pos = 0;
        end
        w = word_store[draw_pos];
        draw_pos++;
        return temper_out(w);
    endfunction

    task automatic report_mismatch(input string what, input t_word exp_w, input t_word got_w);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s: expected %08h, got %08h", what, exp_w, got_w);
        end
    endtask

    always @(posedge i_clk) begin : word_check
        t_word w;
        if (!i_rst_n) begin
            seed_reg = SEED_DEFAULT;
            draw_pos = UNSEEDED;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                seed_reg = i_cfg_data;
                draw_pos = UNSEEDED;
            end
            if (s_axis_tvalid && s_axis_tready && s_axis_tdata[0]) begin
                w = next_word();
                expected_words.push_back(fixed_valid ? fixed_word : w);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word beat", '0, m_axis_tdata);
                end else begin
                    w = expected_words.pop_front();
                    if (m_axis_tdata !== w) begin
                        report_mismatch("random_word", w, m_axis_tdata);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_mersenne_twister_word_generator_core: FAIL");
            $finish;
        end
    end

    initial begin : word_sink
        int unsigned gap;
        int unsigned n;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_len != 0) begin
                n = hold_len;
                hold_len = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            gap = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    task automatic send_request(input logic [7:0] req, input logic known, input t_word word);
        int unsigned gap;
        gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        fixed_valid = known;
        fixed_word  = word;
        s_axis_tdata  <= req;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        send_request(($urandom_range(0, 9) == 0) ? REQ_NONE : REQ_DRAW, 1'b0, '0);
    endtask

    // drop valid and hold until every pending word is out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (expected_words.size() != 0);
    endtask

    task automatic write_seed(input t_word value);
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned n_items;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = REQ_NONE;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            case (DIRECTED[r].kind)
                ROW_SEED: begin
                    write_seed(DIRECTED[r].seed);
                end
                ROW_DRAW: begin
                    send_request(REQ_DRAW, DIRECTED[r].known, DIRECTED[r].word);
                end
                default: begin
                    send_request(REQ_NONE, 1'b0, '0);
                end
            endcase
        end

        // long run of random requests, with a receiver hold and a sender pause
        write_seed($urandom());
        for (int i = 0; i < 660; i++) begin
            if (i % 40 == 0) begin
                src_burst  = ($urandom_range(0, 3) == 0);
                sink_burst = ($urandom_range(0, 3) == 0);
            end
            if (i == 100) begin
                src_burst = 1'b1;
                hold_len  = LONG_HOLD;
            end
            if (i == 300) begin
                drain();
            end
            send_random();
        end

        repeat (6) begin
            src_burst  = ($urandom_range(0, 2) == 0);
            sink_burst = ($urandom_range(0, 2) == 0);
            write_seed(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom());
            n_items = $urandom_range(15, 35);
            repeat (n_items) send_random();
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("tb_mersenne_twister_word_generator_core: PASS");
        end else begin
            $display("tb_mersenne_twister_word_generator_core: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/mtwg_pkg.sv
sv/mtwg_cell.sv
sv/mtwg_seeder.sv
sv/mersenne_twister_word_generator_core.sv
bench/tb_mersenne_twister_word_generator_core.sv
